>>> hw/rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared constants, types and the byte-wide CRC-16 update for the
// write-single-register slave.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned BODY_LEN  = 6;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);
	localparam int unsigned RAM_AW    = POS_W + 1;

	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;

	localparam logic [7:0]  RST_SLAVE_ADDRESS   = 8'd1;
	localparam logic [15:0] RST_TARGET_REGISTER = 16'd1;
	localparam logic [15:0] RST_MAX_VALUE       = 16'd255;

	// byte positions within a frame
	localparam logic [POS_W-1:0] POS_ADDR   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FUNC   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_REG_HI = POS_W'(2);
	localparam logic [POS_W-1:0] POS_REG_LO = POS_W'(3);
	localparam logic [POS_W-1:0] POS_VAL_HI = POS_W'(4);
	localparam logic [POS_W-1:0] POS_VAL_LO = POS_W'(5);
	localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(7);

	typedef enum logic [1:0] {
		CFG_SLAVE_ADDRESS   = 2'd0,
		CFG_TARGET_REGISTER = 2'd1,
		CFG_MAX_VALUE       = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              we;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic        go;
		logic        bank;
		logic [15:0] crc;
		logic [15:0] value;
	} resp_launch_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/mbrtu_rx.sv
// ----------------------------------------------------------------------------
// mbrtu_rx
// Request side: counts bytes into frames, folds the CRC, writes the frame
// body into the response buffer and checks the frame on its last byte.
// ----------------------------------------------------------------------------
module mbrtu_rx (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            slave_address,
	input  logic [15:0]           target_register,
	input  logic [15:0]           max_value,
	input  logic                  resp_busy,
	output mbrtu_pkg::ram_wr_t      wr,
	output mbrtu_pkg::resp_launch_t launch
);
	import mbrtu_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic             bank_q;
	logic [7:0]       crc_lo_q;
	logic [7:0]       addr_q;
	logic             func_ok_q;
	logic [15:0]      reg_q;
	logic [15:0]      val_q;
	logic             accept;
	logic             in_body;
	logic             last_byte;
	logic             frame_ok;

	// last byte waits while the previous response is still being read out
	assign last_byte = (pos_q == POS_CRC_HI);
	assign rx_ready  = !(last_byte && resp_busy);
	assign accept    = rx_valid && rx_ready;
	assign in_body   = (pos_q < POS_W'(BODY_LEN));

	assign frame_ok = ({rx_byte, crc_lo_q} == crc_q) &&
	                  (addr_q == slave_address) &&
	                  func_ok_q &&
	                  (reg_q == target_register) &&
	                  (val_q <= max_value);

	assign wr.we   = accept && in_body;
	assign wr.addr = {bank_q, pos_q};
	assign wr.data = rx_byte;

	assign launch.go    = accept && last_byte && frame_ok;
	assign launch.bank  = bank_q;
	assign launch.crc   = crc_q;
	assign launch.value = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				if (frame_ok) begin
					bank_q <= !bank_q;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (in_body) begin
					crc_q <= crc_fold(crc_q, rx_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (pos_q)
				POS_ADDR:   addr_q      <= rx_byte;
				POS_FUNC:   func_ok_q   <= (rx_byte == FUNC_WRITE_SINGLE);
				POS_REG_HI: reg_q[15:8] <= rx_byte;
				POS_REG_LO: reg_q[7:0]  <= rx_byte;
				POS_VAL_HI: val_q[15:8] <= rx_byte;
				POS_VAL_LO: val_q[7:0]  <= rx_byte;
				POS_CRC_LO: crc_lo_q    <= rx_byte;
				default: ;
			endcase
		end
	end

	a_launch_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		launch.go |-> !resp_busy)
		else $error("response launched while buffer busy");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		launch.go |=> bank_q != $past(bank_q))
		else $error("write bank not switched after accepted frame");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (pos_q == POS_ADDR) && (crc_q == CRC_INIT))
		else $error("frame state not restarted");

endmodule

>>> hw/rtl/mbrtu_resp.sv
// ----------------------------------------------------------------------------
// mbrtu_resp
// Two-bank frame buffer and response read-out: replays the stored body,
// then the CRC low and high bytes, through a registered output word.
// ----------------------------------------------------------------------------
module mbrtu_resp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbrtu_pkg::ram_wr_t      wr,
	input  mbrtu_pkg::resp_launch_t launch,
	output logic                    busy,
	output logic                    tx_valid,
	input  logic                    tx_ready,
	output logic [7:0]              tx_byte,
	output logic                    last_of_response,
	output logic [15:0]             duty_value
);
	import mbrtu_pkg::*;

	logic [7:0]       mem [2**RAM_AW];
	logic             play_q;
	logic [POS_W-1:0] cnt_q;
	logic             bank_q;
	logic [15:0]      crc_q;
	logic [15:0]      val_q;
	logic             valid_s1;
	logic [POS_W-1:0] pos_s1;
	logic [7:0]       rdata_s1;
	logic             tx_valid_q;
	logic [7:0]       tx_byte_q;
	logic             last_q;
	logic [15:0]      duty_q;
	logic             adv_out;
	logic             load_out;
	logic             issue;
	logic [7:0]       out_byte;

	assign adv_out  = !tx_valid_q || tx_ready;
	assign load_out = valid_s1 && adv_out;
	assign issue    = play_q && (!valid_s1 || load_out);
	assign busy     = play_q || valid_s1;

	always_comb begin
		unique case (pos_s1)
			POS_CRC_LO: out_byte = crc_q[7:0];
			POS_CRC_HI: out_byte = crc_q[15:8];
			default:    out_byte = rdata_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= mem[{bank_q, cnt_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q     <= 1'b0;
			cnt_q      <= '0;
			valid_s1   <= 1'b0;
			tx_valid_q <= 1'b0;
		end else begin
			if (launch.go) begin
				play_q <= 1'b1;
				cnt_q  <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + POS_W'(1);
				if (cnt_q == POS_CRC_HI) begin
					play_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (load_out) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				tx_valid_q <= 1'b1;
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch.go) begin
			bank_q <= launch.bank;
			crc_q  <= launch.crc;
			val_q  <= launch.value;
		end
		if (issue) begin
			pos_s1 <= cnt_q;
		end
		if (load_out) begin
			tx_byte_q <= out_byte;
			last_q    <= (pos_s1 == POS_CRC_HI);
			duty_q    <= val_q;
		end
	end

	assign tx_valid         = tx_valid_q;
	assign tx_byte          = tx_byte_q;
	assign last_of_response = last_q;
	assign duty_value       = duty_q;

	a_bank_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.we && busy) |-> (wr.addr[RAM_AW-1] != bank_q))
		else $error("write into bank being read out");

	// crc positions read entries that are never written, so compare by identity
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_out) |=> valid_s1 && $stable(pos_s1) &&
		(rdata_s1 === $past(rdata_s1)))
		else $error("stalled read word lost");

	a_play_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && cnt_q == POS_CRC_HI) |=> !play_q)
		else $error("read-out ran past last byte");

endmodule

>>> hw/rtl/modbus_rtu_write_register_slave.sv
// ----------------------------------------------------------------------------
// modbus_rtu_write_register_slave
// Modbus RTU write-single-register slave: checks fixed 8-byte requests and
// returns the 8-byte echo with the new duty value.
// ----------------------------------------------------------------------------
// Received bytes are framed purely by count from reset, eight to a frame. A
// frame is answered when its CRC-16 is good, the address is slave_address,
// the function is write single register, the register is target_register
// and the value is at most max_value; otherwise it is dropped without a
// word. Bytes are taken one per cycle; only the last byte of a frame waits,
// for as long as the previous response is still being read from the frame
// buffer, which holds two frames in two banks of one memory. A response
// leaves as eight words, one per cycle when tx_ready stays high; its first
// word follows the last request byte through the play flag, memory read and
// output register. Configuration writes are taken in every cycle.
module modbus_rtu_write_register_slave (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        tx_valid,
	input  logic        tx_ready,
	output logic [7:0]  tx_byte,
	output logic        last_of_response,
	output logic [15:0] duty_value
);
	import mbrtu_pkg::*;

	logic [7:0]   slave_address_q;
	logic [15:0]  target_register_q;
	logic [15:0]  max_value_q;
	ram_wr_t      wr;
	resp_launch_t launch;
	logic         resp_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q   <= RST_SLAVE_ADDRESS;
			target_register_q <= RST_TARGET_REGISTER;
			max_value_q       <= RST_MAX_VALUE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLAVE_ADDRESS:   slave_address_q   <= cfg_data[7:0];
				CFG_TARGET_REGISTER: target_register_q <= cfg_data;
				CFG_MAX_VALUE:       max_value_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	mbrtu_rx u_rx (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_valid),
		.rx_ready        (rx_ready),
		.rx_byte         (rx_byte),
		.slave_address   (slave_address_q),
		.target_register (target_register_q),
		.max_value       (max_value_q),
		.resp_busy       (resp_busy),
		.wr              (wr),
		.launch          (launch)
	);

	mbrtu_resp u_resp (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr               (wr),
		.launch           (launch),
		.busy             (resp_busy),
		.tx_valid         (tx_valid),
		.tx_ready         (tx_ready),
		.tx_byte          (tx_byte),
		.last_of_response (last_of_response),
		.duty_value       (duty_value)
	);

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the write-single-register slave. Request frames
// (good, wrong address, function, register, oversized value, bad CRC and
// shifted streams) are pushed with random gaps. A running model of the
// frame checker predicts each echo word, and the words read back are
// compared in order. Several register settings are used, including the
// lowest and highest values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import mbrtu_pkg::*;

typedef struct packed {
	logic [7:0]  data;
	logic        last;
	logic [15:0] duty;
} tx_word_t;

localparam logic [1:0] CFG_IDX_NONE = 2'd3;

function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
	logic [15:0] r;
	logic        fb;
	r = acc;
	for (int i = 0; i < 8; i++) begin
		fb = r[0] ^ b[i];
		r  = r >> 1;
		if (fb)
			r = r ^ CRC_POLY;
	end
	return r;
endfunction

class echo_tracker;
	logic [7:0]  addr_cfg;
	logic [15:0] reg_cfg;
	logic [15:0] max_cfg;
	logic [2:0]  pos;
	logic [15:0] crc;
	logic [7:0]  body [BODY_LEN];
	logic [7:0]  crc_lo;
	tx_word_t    echo_q [$];
	int          errors;
	int          words_checked;
	int          frames_answered;
	int          frames_dropped;
	int          bytes_taken;

	function new();
		addr_cfg        = RST_SLAVE_ADDRESS;
		reg_cfg         = RST_TARGET_REGISTER;
		max_cfg         = RST_MAX_VALUE;
		pos             = '0;
		crc             = CRC_INIT;
		crc_lo          = '0;
		errors          = 0;
		words_checked   = 0;
		frames_answered = 0;
		frames_dropped  = 0;
		bytes_taken     = 0;
		foreach (body[i])
			body[i] = '0;
	endfunction

	function void write_reg(input logic [1:0] idx, input logic [15:0] d);
		case (idx)
			CFG_SLAVE_ADDRESS:   addr_cfg = d[7:0];
			CFG_TARGET_REGISTER: reg_cfg  = d;
			CFG_MAX_VALUE:       max_cfg  = d;
			default: ;
		endcase
	endfunction

	function int pending();
		return echo_q.size();
	endfunction

	function void take_rx_byte(input logic [7:0] b);
		logic [15:0] rx_crc;
		logic [15:0] regn;
		logic [15:0] val;
		tx_word_t    w;
		bytes_taken++;
		if (pos < POS_CRC_LO) begin
			body[pos] = b;
			crc       = crc16_update(crc, b);
			pos       = pos + 3'd1;
		end else if (pos == POS_CRC_LO) begin
			crc_lo = b;
			pos    = pos + 3'd1;
		end else begin
			rx_crc = {b, crc_lo};
			regn   = {body[POS_REG_HI], body[POS_REG_LO]};
			val    = {body[POS_VAL_HI], body[POS_VAL_LO]};
			if (rx_crc == crc && body[POS_ADDR] == addr_cfg &&
			    body[POS_FUNC] == FUNC_WRITE_SINGLE && regn == reg_cfg && val <= max_cfg) begin
				for (int k = 0; k < FRAME_LEN; k++) begin
					w.data = (k < BODY_LEN) ? body[k] : (k == BODY_LEN) ? crc[7:0] : crc[15:8];
					w.last = (k == FRAME_LEN - 1);
					w.duty = val;
					echo_q.push_back(w);
				end
				frames_answered++;
			end else begin
				frames_dropped++;
			end
			pos = '0;
			crc = CRC_INIT;
		end
	endfunction

	task report(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_tx_word(input tx_word_t got);
		tx_word_t exp;
		if (echo_q.size() == 0) begin
			report($sformatf("unexpected word %02h last %0b duty %04h",
			                 got.data, got.last, got.duty));
		end else begin
			exp = echo_q.pop_front();
			words_checked++;
			if (got.data !== exp.data)
				report($sformatf("tx_byte %02h, expected %02h", got.data, exp.data));
			if (got.last !== exp.last)
				report($sformatf("last_of_response %0b, expected %0b", got.last, exp.last));
			if (got.duty !== exp.duty)
				report($sformatf("duty_value %04h, expected %04h", got.duty, exp.duty));
		end
	endtask
endclass

module tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;

	typedef enum {
		REQ_GOOD,
		REQ_BAD_ADDR,
		REQ_BAD_FUNC,
		REQ_BAD_REG,
		REQ_BIG_VALUE,
		REQ_BAD_CRC,
		REQ_SHIFTED
	} req_kind_t;

	logic        clk;
	logic        arst_n           = 1'b0;
	logic        cfg_valid        = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index        = '0;
	logic [15:0] cfg_data         = '0;
	logic        rx_valid         = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte          = '0;
	logic        tx_valid;
	logic        tx_ready         = 1'b0;
	logic [7:0]  tx_byte;
	logic        last_of_response;
	logic [15:0] duty_value;

	echo_tracker sb = new();

	logic [7:0]  cur_addr  = RST_SLAVE_ADDRESS;
	logic [15:0] cur_reg   = RST_TARGET_REGISTER;
	logic [15:0] cur_max   = RST_MAX_VALUE;
	int          stream_pos = 0;
	int          settings_used = 1;
	bit          rx_quiet  = 1'b0;
	bit          tx_quiet  = 1'b0;
	bit          hold_req  = 1'b0;

	modbus_rtu_write_register_slave u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rx_valid         (rx_valid),
		.rx_ready         (rx_ready),
		.rx_byte          (rx_byte),
		.tx_valid         (tx_valid),
		.tx_ready         (tx_ready),
		.tx_byte          (tx_byte),
		.last_of_response (last_of_response),
		.duty_value       (duty_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && tx_valid && tx_ready)
			sb.check_tx_word(tx_word_t'{tx_byte, last_of_response, duty_value});
	end

	// response side: random stalls, plus one long hold on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				gap      = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = tx_quiet ? 0 : $urandom_range(0, 11);
			end
			if (gap > 0) begin
				tx_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx_ready <= 1'b1;
			do @(posedge clk); while (!(tx_valid && tx_ready) && !hold_req);
		end
	end

	task send_byte(input logic [7:0] b);
		int gap;
		gap = rx_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		sb.take_rx_byte(b);
		stream_pos = (stream_pos + 1) % FRAME_LEN;
	endtask

	task pad_to_frame();
		while (stream_pos != 0)
			send_byte(8'($urandom));
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return cur_max;
			default: return 16'($urandom_range(0, cur_max));
		endcase
	endfunction

	task send_frame(input req_kind_t kind, input logic [15:0] val);
		logic [7:0]  req [FRAME_LEN];
		logic [15:0] crc;
		logic [15:0] regn;
		logic [7:0]  func;
		logic [7:0]  addr;
		addr = cur_addr;
		func = FUNC_WRITE_SINGLE;
		regn = cur_reg;
		case (kind)
			REQ_BAD_ADDR: addr = cur_addr ^ 8'($urandom_range(1, 255));
			REQ_BAD_FUNC: func = FUNC_WRITE_SINGLE ^ 8'($urandom_range(1, 255));
			REQ_BAD_REG:  regn = cur_reg ^ 16'($urandom_range(1, 65535));
			REQ_BIG_VALUE: begin
				if (cur_max != 16'hFFFF)
					val = 16'($urandom_range(int'(cur_max) + 1, 65535));
			end
			REQ_SHIFTED: begin
				repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
			end
			default: ;
		endcase
		req[POS_ADDR]   = addr;
		req[POS_FUNC]   = func;
		req[POS_REG_HI] = regn[15:8];
		req[POS_REG_LO] = regn[7:0];
		req[POS_VAL_HI] = val[15:8];
		req[POS_VAL_LO] = val[7:0];
		crc = CRC_INIT;
		for (int k = 0; k < BODY_LEN; k++)
			crc = crc16_update(crc, req[k]);
		if (kind == REQ_BAD_CRC)
			crc = crc ^ 16'($urandom_range(1, 65535));
		req[POS_CRC_LO] = crc[7:0];
		req[POS_CRC_HI] = crc[15:8];
		for (int k = 0; k < FRAME_LEN; k++)
			send_byte(req[k]);
	endtask

	// finish the current frame, then let every echo word come out
	task drain();
		pad_to_frame();
		rx_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(input logic [1:0] idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
	endtask

	task apply_config(input logic [15:0] addr_word, input logic [15:0] regn,
	                  input logic [15:0] maxv, input bit poke_unused);
		write_reg(CFG_SLAVE_ADDRESS, addr_word);
		write_reg(CFG_TARGET_REGISTER, regn);
		write_reg(CFG_MAX_VALUE, maxv);
		if (poke_unused)
			write_reg(CFG_IDX_NONE, 16'($urandom));
		cfg_valid <= 1'b0;
		cur_addr = addr_word[7:0];
		cur_reg  = regn;
		cur_max  = maxv;
		settings_used++;
	endtask

	task random_frames(input int n);
		int r;
		req_kind_t kind;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 60)      kind = REQ_GOOD;
			else if (r < 67) kind = REQ_BAD_ADDR;
			else if (r < 73) kind = REQ_BAD_FUNC;
			else if (r < 79) kind = REQ_BAD_REG;
			else if (r < 85) kind = REQ_BIG_VALUE;
			else if (r < 93) kind = REQ_BAD_CRC;
			else             kind = REQ_SHIFTED;
			send_frame(kind, pick_value());
			if (kind == REQ_SHIFTED)
				pad_to_frame();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: value at the limit, bad crc, stream shifted by one byte
		send_frame(REQ_GOOD, cur_max);
		send_frame(REQ_BAD_CRC, 16'h0000);
		send_byte(8'hA5);
		send_frame(REQ_GOOD, 16'h0001);
		drain();

		apply_config(16'h0000, 16'h0000, 16'h0000, 1'b1);
		random_frames(6);
		drain();

		// long response stall with back-to-back requests
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		rx_quiet = 1'b1;
		hold_req = 1'b1;
		repeat (4) send_frame(REQ_GOOD, pick_value());
		random_frames(3);
		rx_quiet = 1'b0;
		drain();

		apply_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)), 1'b1);
		random_frames(6);
		drain();

		apply_config(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
		tx_quiet = 1'b1;
		random_frames(6);
		tx_quiet = 1'b0;
		drain();

		apply_config(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		random_frames(6);
		drain();

		$display("sent %0d request bytes: %0d frames answered, %0d dropped",
		         sb.bytes_taken, sb.frames_answered, sb.frames_dropped);
		$display("checked %0d echo words over %0d register settings",
		         sb.words_checked, settings_used);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/mbrtu_pkg.sv
hw/rtl/mbrtu_rx.sv
hw/rtl/mbrtu_resp.sv
hw/rtl/modbus_rtu_write_register_slave.sv
verif/tb.sv
